/* src/rbct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbct_pkg
// shared types and constants of the red blob centroid tracker
// ----------------------------------------------------------------------------
package rbct_pkg;

  // default raster limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // field widths
  localparam int LINE_WIDTH_W = 11;
  localparam int THR_W        = 8;
  localparam int COLOR_W      = 8;
  localparam int COUNT_W      = 21;
  localparam int CENT_W       = 10;

  // register reset values
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 11'd320;
  localparam logic [THR_W-1:0]        CR_THR_RST     = 8'd180;

  // register indexes
  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_CR_THRESHOLD = 1'b1;

  // q16 coefficients; red term folds in r*65536 - 0.299*r
  localparam logic signed [16:0] COEF_RD   = 17'sd45941;
  localparam logic signed [16:0] COEF_G    = 17'sd38470;
  localparam logic signed [16:0] COEF_B    = 17'sd7471;
  localparam logic signed [16:0] COEF_CR   = 17'sd46727;
  localparam logic signed [8:0]  CR_OFFSET = 9'sd128;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last_pixel;
  } pix_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pixel_count;
    logic [CENT_W-1:0]  centroid_column;
    logic [CENT_W-1:0]  centroid_row;
    logic               found;
  } res_t;

endpackage

/* src/red_blob_centroid_tracker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// red_blob_centroid_tracker_core
// chroma threshold pixel marking and per-frame blob centroid
// ----------------------------------------------------------------------------
// Pixels come in raster order, one beat per pixel. Each pixel is marked when
// its Cr chroma, (R - Y) * 0.713 + 128 with exact q16 coefficients, is strictly
// above cr_threshold; marked pixels add to a count and to sums of their column
// and row. In a pixel beat one shared 25x17 multiplier forms the red, green
// and blue terms and then the Cr scale in turn; pixel_ready is high only in
// ST_IDLE, so the next pixel waits for the beat. On the frame's last pixel the
// same beat also runs two divisions through one restoring divider, one
// quotient bit per cycle, for QW-bit quotients (QW = clog2 of the larger of
// MAX_WIDTH and MAX_HEIGHT, 10 by default); an empty frame skips the divisions.
// A finished result sits in an output register and the next frame may start
// while it waits for result_ready; a second frame end that finds the register
// still full holds the sequencer, and pixel_ready stays low until the first
// result leaves. An empty frame reports found = 0 with a zero centroid.
// Registers: line_width at 0x0 and cr_threshold at 0x4; the user must write
// them only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module red_blob_centroid_tracker_core #(
  parameter int MAX_WIDTH  = rbct_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rbct_pkg::MAX_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  // pixel channel
  input  rbct_pkg::pix_t pixel,
  input  logic           pixel_valid,
  output logic           pixel_ready,
  // result channel
  output rbct_pkg::res_t result,
  output logic           result_valid,
  input  logic           result_ready,
  // register port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CAP  = MAX_WIDTH * MAX_HEIGHT;
  localparam int NW   = $clog2(CAP) + 1;
  localparam int QW   = (CW > RW) ? CW : RW;
  localparam int SW   = NW + QW;
  localparam int CMPW = (CW + 1 > rbct_pkg::LINE_WIDTH_W) ? CW + 1 : rbct_pkg::LINE_WIDTH_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_G,
    ST_MUL_B,
    ST_SUB,
    ST_MUL_CR,
    ST_ACCUM,
    ST_DIV_COL_GO,
    ST_DIV_COL_WAIT,
    ST_DIV_ROW_GO,
    ST_DIV_ROW_WAIT,
    ST_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [rbct_pkg::LINE_WIDTH_W-1:0] line_width;
  logic [rbct_pkg::THR_W-1:0]        cr_threshold;
  logic                              reg_idx;
  logic                              reg_wr;

  // pixel payload held across the beat
  logic [rbct_pkg::COLOR_W-1:0] green_q;
  logic [rbct_pkg::COLOR_W-1:0] blue_q;
  logic                         last_q;

  // shared multiplier and chroma difference accumulator
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] prod;
  logic signed [24:0] acc;
  logic signed [8:0]  thr_diff;
  logic signed [41:0] thr_rhs;
  logic               marked;

  // raster position and frame accumulators
  logic [CW-1:0] column_counter;
  logic [RW-1:0] row_counter;
  logic [NW-1:0] marked_count;
  logic [SW-1:0] column_sum;
  logic [SW-1:0] row_sum;
  logic [CMPW-1:0] lw_ext;
  logic [CMPW-1:0] w_eff;
  logic            wrap;

  // divider hookup
  logic          div_start;
  logic [SW-1:0] div_dividend;
  logic          div_done;
  logic [QW-1:0] div_q;
  logic [QW-1:0] q_col;
  logic [QW-1:0] q_row;

  // ---------------------------------------------------------------- registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      rbct_pkg::REG_LINE_WIDTH:   prdata = 32'(line_width);
      rbct_pkg::REG_CR_THRESHOLD: prdata = 32'(cr_threshold);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= rbct_pkg::LINE_WIDTH_RST;
      cr_threshold <= rbct_pkg::CR_THR_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        rbct_pkg::REG_LINE_WIDTH:   line_width   <= pwdata[rbct_pkg::LINE_WIDTH_W-1:0];
        rbct_pkg::REG_CR_THRESHOLD: cr_threshold <= pwdata[rbct_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- shared multiplier
  // operand select follows the sequencer; product registered every cycle
  always_comb begin
    unique case (state)
      ST_IDLE: begin
        mul_a = $signed({17'b0, pixel.red});
        mul_b = rbct_pkg::COEF_RD;
      end
      ST_MUL_G: begin
        mul_a = $signed({17'b0, green_q});
        mul_b = rbct_pkg::COEF_G;
      end
      ST_MUL_B: begin
        mul_a = $signed({17'b0, blue_q});
        mul_b = rbct_pkg::COEF_B;
      end
      ST_MUL_CR: begin
        mul_a = acc;
        mul_b = rbct_pkg::COEF_CR;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // marked when d * 0.713 (q32) > (threshold - 128) << 32
  assign thr_diff = $signed({1'b0, cr_threshold}) - rbct_pkg::CR_OFFSET;
  assign thr_rhs  = {thr_diff[8], thr_diff, 32'b0};
  assign marked   = (prod > thr_rhs) && (marked_count < NW'(CAP));

  // effective line width, clamped to 1 .. MAX_WIDTH
  assign lw_ext = CMPW'(line_width);
  always_comb begin
    priority if (lw_ext == '0) begin
      w_eff = CMPW'(1);
    end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
  end
  assign wrap = (CMPW'(column_counter) + CMPW'(1)) >= w_eff;

  // ------------------------------------------------------------------ divider
  assign div_start    = ((state == ST_DIV_COL_GO) && (marked_count != '0)) ||
                        (state == ST_DIV_ROW_GO);
  assign div_dividend = (state == ST_DIV_ROW_GO) ? row_sum : column_sum;

  rbct_div #(
    .DVD_W (SW),
    .DVS_W (NW),
    .Q_W   (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (marked_count),
    .done     (div_done),
    .quotient (div_q)
  );

  assign pixel_ready = (state == ST_IDLE);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      result_valid   <= 1'b0;
      column_counter <= '0;
      row_counter    <= '0;
      marked_count   <= '0;
      column_sum     <= '0;
      row_sum        <= '0;
    end else begin
      // in ST_DONE the output register is reloaded whenever result_ready is high
      if (result_ready && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pixel_valid) begin
            green_q <= pixel.green;
            blue_q  <= pixel.blue;
            last_q  <= pixel.last_pixel;
            state   <= ST_MUL_G;
          end
        end
        ST_MUL_G: begin
          acc   <= prod[24:0];
          state <= ST_MUL_B;
        end
        ST_MUL_B: begin
          acc   <= acc - prod[24:0];
          state <= ST_SUB;
        end
        ST_SUB: begin
          acc   <= acc - prod[24:0];
          state <= ST_MUL_CR;
        end
        ST_MUL_CR: begin
          state <= ST_ACCUM;
        end
        ST_ACCUM: begin
          if (marked) begin
            marked_count <= marked_count + NW'(1);
            column_sum   <= column_sum + SW'(column_counter);
            row_sum      <= row_sum + SW'(row_counter);
          end
          if (last_q) begin
            column_counter <= '0;
            row_counter    <= '0;
            state          <= ST_DIV_COL_GO;
          end else begin
            if (wrap) begin
              column_counter <= '0;
              if (row_counter != RW'(MAX_HEIGHT - 1)) begin
                row_counter <= row_counter + RW'(1);
              end
            end else begin
              column_counter <= column_counter + CW'(1);
            end
            state <= ST_IDLE;
          end
        end
        ST_DIV_COL_GO: begin
          // empty frame skips both divisions
          if (marked_count == '0) begin
            q_col <= '0;
            q_row <= '0;
            state <= ST_DONE;
          end else begin
            state <= ST_DIV_COL_WAIT;
          end
        end
        ST_DIV_COL_WAIT: begin
          if (div_done) begin
            q_col <= div_q;
            state <= ST_DIV_ROW_GO;
          end
        end
        ST_DIV_ROW_GO: begin
          state <= ST_DIV_ROW_WAIT;
        end
        ST_DIV_ROW_WAIT: begin
          if (div_done) begin
            q_row <= div_q;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // load the output register once the previous result has left
          if (!result_valid || result_ready) begin
            result.pixel_count     <= rbct_pkg::COUNT_W'(marked_count);
            result.centroid_column <= rbct_pkg::CENT_W'(q_col);
            result.centroid_row    <= rbct_pkg::CENT_W'(q_row);
            result.found           <= (marked_count != '0);
            result_valid           <= 1'b1;
            marked_count           <= '0;
            column_sum             <= '0;
            row_sum                <= '0;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/rbct_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbct_div
// restoring divider, one quotient bit per cycle, quotient known to fit q_w bits
// ----------------------------------------------------------------------------
module rbct_div #(
  parameter int DVD_W = 31,
  parameter int DVS_W = 21,
  parameter int Q_W   = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  localparam int SCW = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic             busy;
  logic [SCW-1:0]   step;
  logic [DVD_W-1:0] rem;
  logic [DVD_W-1:0] dsh;
  logic             ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quotient <= (quotient << 1) | Q_W'(ge);
        dsh      <= dsh >> 1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - SCW'(1);
        end
      end else if (start) begin
        rem      <= dividend;
        dsh      <= DVD_W'(divisor) << (Q_W - 1);
        quotient <= '0;
        step     <= SCW'(Q_W - 1);
        busy     <= 1'b1;
      end
    end
  end

endmodule

/* src/rbct_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbct_checker
// port-level checks of the red blob centroid tracker, bound to the top level
// ----------------------------------------------------------------------------
module rbct_checker (
  input logic           clk,
  input logic           rst,
  input rbct_pkg::pix_t pixel,
  input logic           pixel_valid,
  input logic           pixel_ready,
  input rbct_pkg::res_t result,
  input logic           result_valid,
  input logic           result_ready
);

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // empty frame reports a zero centroid
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |->
      result.pixel_count == '0 && result.centroid_column == '0 &&
      result.centroid_row == '0)
    else $error("empty frame with nonzero fields");

  // a pixel beat occupies the multiplier and blocks a back-to-back beat
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("pixel taken on back-to-back cycles");

  // a pixel that does not end a frame never raises a result
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready && !pixel.last_pixel |=> !$rose(result_valid))
    else $error("result raised without a frame end");

endmodule

bind red_blob_centroid_tracker_core rbct_checker u_rbct_checker (.*);

/* dv/tb_red_blob_centroid_tracker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_red_blob_centroid_tracker_core
// self-checking bench for the chroma threshold blob centroid core
// ----------------------------------------------------------------------------
// Pixel beats go in through a valid/ready channel. A q16 model of the core
// runs alongside: it marks each accepted pixel by its Cr chroma, follows the
// raster position and keeps the frame sums. At each frame end it queues the
// expected centroid beat. A monitor compares every result beat field by field
// with the oldest queued one. Directed frames cover the color and register
// extremes and a line width change mid-row. A tall one-pixel-wide frame walks
// the row counter and a long row walks the column counter. A long result stall
// runs before random frames under shifting settings, then a final stretch with
// no idling on either side. Every register write is read back.
// ----------------------------------------------------------------------------
module tb_red_blob_centroid_tracker_core;

  // q16 luma and chroma coefficients
  localparam longint Q_LUMA_R   = 19595;
  localparam longint Q_LUMA_G   = 38470;
  localparam longint Q_LUMA_B   = 7471;
  localparam longint Q_CR_SCALE = 46727;
  localparam longint CR_MID     = 128;

  localparam int     MAX_W       = rbct_pkg::MAX_WIDTH_DEF;
  localparam int     MAX_H       = rbct_pkg::MAX_HEIGHT_DEF;
  localparam longint MARK_CAP    = longint'(MAX_W) * longint'(MAX_H);
  // pixel beat plus the two divisions at frame end, with margin
  localparam int     SETTLE      = 48;
  localparam int     DRAIN_LIMIT = 20000;
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     LONG_HOLD   = 300;

  logic           clk = 1'b0;
  logic           rst;
  rbct_pkg::pix_t pixel;
  logic           pixel_valid;
  logic           pixel_ready;
  rbct_pkg::res_t result;
  logic           result_valid;
  logic           result_ready;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  // model copy of the registers and the frame state
  logic [10:0] cfg_line_width;
  logic [7:0]  cfg_cr_threshold;
  int          raster_col;
  int          raster_row;
  longint      marked_pixels;
  longint      col_total;
  longint      row_total;

  // centroid beats still owed by the core, oldest first
  rbct_pkg::res_t pending_blobs[$];

  int          mismatches      = 0;
  int          pixels_sent     = 0;
  int          frames_sent     = 0;
  int          blobs_checked   = 0;
  int          blobs_found     = 0;
  int          cycle_count     = 0;
  bit          gaps_on         = 1'b1;
  bit          stalls_on       = 1'b1;
  bit          long_hold_req   = 1'b0;

  always #5 clk = ~clk;

  red_blob_centroid_tracker_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel        (pixel),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // one accepted pixel through the model; queues a beat on the frame's end
  task automatic track_pixel(input rbct_pkg::pix_t p);
    longint         luma;
    longint         chroma_q32;
    longint         bound_q32;
    longint         quot;
    int             w;
    rbct_pkg::res_t blob;
    w = (cfg_line_width == 0) ? 1 : (cfg_line_width > MAX_W) ? MAX_W : int'(cfg_line_width);
    luma = Q_LUMA_R * longint'(p.red) + Q_LUMA_G * longint'(p.green)
         + Q_LUMA_B * longint'(p.blue);
    // exact compare of (r - y) * 0.713 against threshold - 128, both in q32
    chroma_q32 = (longint'(p.red) * 65536 - luma) * Q_CR_SCALE;
    bound_q32  = (longint'(cfg_cr_threshold) - CR_MID) * (longint'(1) << 32);
    if (chroma_q32 > bound_q32 && marked_pixels < MARK_CAP) begin
      marked_pixels++;
      col_total += raster_col;
      row_total += raster_row;
    end
    if (p.last_pixel) begin
      blob = '0;
      blob.pixel_count = marked_pixels[20:0];
      // empty frame keeps a zero centroid and no division
      if (marked_pixels != 0) begin
        quot = col_total / marked_pixels;
        blob.centroid_column = quot[9:0];
        quot = row_total / marked_pixels;
        blob.centroid_row = quot[9:0];
        blob.found = 1'b1;
      end
      pending_blobs.push_back(blob);
      raster_col    = 0;
      raster_row    = 0;
      marked_pixels = 0;
      col_total     = 0;
      row_total     = 0;
    end else if (raster_col + 1 >= w) begin
      // also covers a width shrunk below the current column
      raster_col = 0;
      if (raster_row + 1 < MAX_H) raster_row++;
    end else begin
      raster_col++;
    end
  endtask

  function automatic rbct_pkg::pix_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b, input bit last);
    rbct_pkg::pix_t p;
    p.red        = r;
    p.green      = g;
    p.blue       = b;
    p.last_pixel = last;
    return p;
  endfunction

  // a quarter of the pixels lean red so that marks are common
  function automatic rbct_pkg::pix_t rand_pixel(input bit last);
    rbct_pkg::pix_t p;
    if ($urandom_range(0, 3) == 0) begin
      p.red   = 8'($urandom_range(160, 255));
      p.green = 8'($urandom_range(0, 60));
      p.blue  = 8'($urandom_range(0, 60));
    end else begin
      {p.red, p.green, p.blue} = 24'($urandom);
    end
    p.last_pixel = last;
    return p;
  endfunction

  // valid stays high across back-to-back beats and drops only in a gap
  task automatic send_pixel(input rbct_pkg::pix_t p);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    pixel       <= p;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    track_pixel(p);
    pixels_sent++;
    if (p.last_pixel) frames_sent++;
  endtask

  // everything owed has come out and the last pixel beat has settled
  task automatic wait_block_idle();
    pixel_valid <= 1'b0;
    while (pending_blobs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // setup cycle then access cycle; the register takes the value at the end of the access cycle,
  // then a read through its own setup and access cycles checks the stored value
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] want_rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == rbct_pkg::REG_LINE_WIDTH) begin
      cfg_line_width = value[10:0];
      want_rd = 32'(value[10:0]);
    end else begin
      cfg_cr_threshold = value[7:0];
      want_rd = 32'(value[7:0]);
    end
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready !== 1'b1) report_mismatch("pready", pready, 1);
    if (prdata !== want_rd) report_mismatch("register read-back", prdata, want_rd);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_pixel(rand_pixel(i == len - 1));
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall bursts and a counted long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left--;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        hold_left = $urandom_range(0, 7);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rbct_pkg::res_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_blobs.size() == 0) begin
        report_mismatch("result beat with nothing pending, pixel_count",
                        result.pixel_count, 0);
      end else begin
        want = pending_blobs.pop_front();
        if (result.pixel_count !== want.pixel_count)
          report_mismatch("pixel_count", result.pixel_count, want.pixel_count);
        if (result.centroid_column !== want.centroid_column)
          report_mismatch("centroid_column", result.centroid_column, want.centroid_column);
        if (result.centroid_row !== want.centroid_row)
          report_mismatch("centroid_row", result.centroid_row, want.centroid_row);
        if (result.found !== want.found)
          report_mismatch("found", result.found, want.found);
        blobs_checked++;
        if (want.found) blobs_found++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats pending", cycle_count,
               pending_blobs.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset register values: color extremes, then an empty frame
  task automatic test_defaults();
    send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd200, 8'd40, 8'd30, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
    // empty frame: zero centroid, found low
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
    wait_block_idle();
  endtask

  // threshold at both ends, width 0 (used as 1) and 2047 (used as max)
  task automatic test_config_extremes();
    write_reg(rbct_pkg::REG_CR_THRESHOLD, 32'd255);
    send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b1));
    wait_block_idle();
    write_reg(rbct_pkg::REG_CR_THRESHOLD, 32'd0);
    send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 1'b1));
    wait_block_idle();
    write_reg(rbct_pkg::REG_LINE_WIDTH, 32'd0);
    for (int i = 0; i < 3; i++) send_pixel(make_pixel(8'd255, 8'd0, 8'd0, i == 2));
    wait_block_idle();
    write_reg(rbct_pkg::REG_LINE_WIDTH, 32'd2047);
    for (int i = 0; i < 3; i++) send_pixel(make_pixel(8'd255, 8'd0, 8'd0, i == 2));
    wait_block_idle();
  endtask

  // shrink the line past the current column partway through a row
  task automatic test_width_change_mid_row();
    write_reg(rbct_pkg::REG_LINE_WIDTH, 32'd8);
    write_reg(rbct_pkg::REG_CR_THRESHOLD, 32'd180);
    for (int i = 0; i < 6; i++) send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
    wait_block_idle();
    write_reg(rbct_pkg::REG_LINE_WIDTH, 32'd3);
    send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd250, 8'd10, 8'd5, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b1));
    wait_block_idle();
  endtask

  // one pixel per row for many rows; marks only near the bottom
  task automatic test_tall_frame();
    write_reg(rbct_pkg::REG_LINE_WIDTH, 32'd1);
    write_reg(rbct_pkg::REG_CR_THRESHOLD, 32'd128);
    for (int i = 0; i < 100; i++) begin
      if (i < 80) send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
      else send_pixel(rand_pixel(i == 99));
    end
    wait_block_idle();
  endtask

  // one long row with marks only at its right end
  task automatic test_wide_row();
    write_reg(rbct_pkg::REG_LINE_WIDTH, 32'd256);
    write_reg(rbct_pkg::REG_CR_THRESHOLD, 32'd140);
    for (int i = 0; i < 256; i++) begin
      if (i < 240) send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
      else if (i == 250) send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
      else send_pixel(rand_pixel(i == 255));
    end
    wait_block_idle();
  endtask

  // result side held off while short frames keep coming, so the core backs up
  task automatic test_backpressure();
    write_reg(rbct_pkg::REG_LINE_WIDTH, 32'd4);
    write_reg(rbct_pkg::REG_CR_THRESHOLD, 32'd150);
    long_hold_req = 1'b1;
    for (int f = 0; f < 12; f++) send_frame($urandom_range(1, 3));
    wait_block_idle();
  endtask

  function automatic logic [31:0] pick_width();
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1:       return 32'd2047;
      2:       return 32'd1024;
      3:       return 32'd1025;
      4:       return 32'($urandom_range(0, 2047));
      default: return 32'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [31:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'd255;
      2:       return 32'($urandom_range(0, 255));
      default: return 32'($urandom_range(110, 220));
    endcase
  endfunction

  // random frames under random settings, idling on both sides
  task automatic test_random_frames(input int pixel_budget);
    int start;
    int len;
    start = pixels_sent;
    while (pixels_sent - start < pixel_budget) begin
      if ($urandom_range(0, 5) == 0) begin
        wait_block_idle();
        if ($urandom_range(0, 2) != 0) write_reg(rbct_pkg::REG_LINE_WIDTH, pick_width());
        if ($urandom_range(0, 2) != 0)
          write_reg(rbct_pkg::REG_CR_THRESHOLD, pick_threshold());
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 24);
      send_frame(len);
    end
    wait_block_idle();
  endtask

  // back-to-back beats with the result side always ready
  task automatic test_streaming(input int pixel_budget);
    int start;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_reg(rbct_pkg::REG_LINE_WIDTH, 32'd7);
    write_reg(rbct_pkg::REG_CR_THRESHOLD, 32'd160);
    start = pixels_sent;
    while (pixels_sent - start < pixel_budget) send_frame($urandom_range(1, 20));
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int waited;
    rst              = 1'b1;
    pixel            = '0;
    pixel_valid      = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    cfg_line_width   = rbct_pkg::LINE_WIDTH_RST;
    cfg_cr_threshold = rbct_pkg::CR_THR_RST;
    raster_col       = 0;
    raster_row       = 0;
    marked_pixels    = 0;
    col_total        = 0;
    row_total        = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_config_extremes();
    test_width_change_mid_row();
    test_tall_frame();
    test_wide_row();
    test_backpressure();
    test_random_frames(400);
    test_streaming(150);

    // drain what is still owed, bounded
    pixel_valid <= 1'b0;
    waited = 0;
    while (pending_blobs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (pending_blobs.size() != 0)
      report_mismatch("result beats never delivered", pending_blobs.size(), 0);

    $display("%0d pixels in %0d frames, %0d centroid beats checked, %0d with a blob",
             pixels_sent, frames_sent, blobs_checked, blobs_found);
    $display("widths 0..2047 incl. clamping, thresholds 0..255, row and column walks, "
             , "mid-row width change, long result stall, register read-back");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
